### rtl/v3acc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package v3acc_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int DATA_W     = 32;
    localparam int PROD_W     = 2 * DATA_W;
    localparam int ACC_W      = PROD_W + 1;
    localparam int DIV_W      = DATA_W + FRAC_BITS;
    localparam int SQRT_STEPS = DATA_W;
    localparam int CNT_W      = $clog2(DIV_W);

    typedef enum logic [1:0] {
        KIND_LOAD  = 2'd0,
        KIND_ADD   = 2'd1,
        KIND_CROSS = 2'd2,
        KIND_NORM  = 2'd3
    } kind_t;

    typedef enum logic [4:0] {
        CMD_NOP,
        CMD_LATCH,
        CMD_LOAD,
        CMD_ADD,
        CMD_PROD_CR,
        CMD_PROD_SQ,
        CMD_ACC_SET,
        CMD_ACC_ADD,
        CMD_ACC_SUB,
        CMD_CR_WR,
        CMD_SQRT_INIT,
        CMD_SQRT_STEP,
        CMD_DIV_INIT,
        CMD_DIV_STEP,
        CMD_DIV_WR,
        CMD_COMMIT,
        CMD_OUT
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t     op;
        logic [1:0]  comp;
        logic        half;
    } cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  vec_zero;
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_CR_PROD,
        ST_CR_ACC,
        ST_CR_WR,
        ST_SQ_PROD,
        ST_SQ_ACC,
        ST_SQRT_INIT,
        ST_SQRT_STEP,
        ST_DIV_INIT,
        ST_DIV_STEP,
        ST_DIV_WR,
        ST_COMMIT,
        ST_DONE
    } state_t;

endpackage
`default_nettype wire

### rtl/v3acc_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
module v3acc_dpath
    import v3acc_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire cmd_t                     cmd,
    output status_t                       status,
    input  wire logic [1:0]               in_kind,
    input  wire logic signed [DATA_W-1:0] in_x,
    input  wire logic signed [DATA_W-1:0] in_y,
    input  wire logic signed [DATA_W-1:0] in_z,
    output logic signed [DATA_W-1:0]      out_x,
    output logic signed [DATA_W-1:0]      out_y,
    output logic signed [DATA_W-1:0]      out_z,
    output logic                          out_sat
);

    localparam logic signed [DATA_W-1:0] S_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] S_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    kind_t                      kind_reg;
    logic signed [DATA_W-1:0]   op_reg  [3];
    logic signed [DATA_W-1:0]   vec_reg [3];
    logic signed [DATA_W-1:0]   res_reg [3];
    logic                       sat_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic [PROD_W-1:0]          rad_reg;
    logic [DATA_W+1:0]          srem_reg;
    logic [DATA_W-1:0]          root_reg;
    logic [DIV_W-1:0]           dvd_reg;
    logic [DATA_W-1:0]          drem_reg;
    logic [DIV_W-1:0]           quo_reg;
    logic signed [DATA_W-1:0]   ox_reg, oy_reg, oz_reg;
    logic                       osat_reg;

    logic signed [DATA_W:0]     mul_a, mul_b;
    logic signed [2*DATA_W+1:0] mul_p;
    logic [DATA_W-1:0]          mag_sel;
    logic signed [DATA_W:0]     sum [3];
    logic signed [ACC_W-1:0]    acc_sh;
    logic [DATA_W-1:0]          cr_val;
    logic                       cr_ovf;
    logic [DATA_W+3:0]          s_sh, s_trial;
    logic [DATA_W:0]            d_sh;
    logic [DATA_W-1:0]          divisor;
    logic [DATA_W-1:0]          q_lo;

    always_comb
    begin
        mag_sel = vec_reg[cmd.comp][DATA_W-1] ? DATA_W'(-vec_reg[cmd.comp])
                                              : DATA_W'(vec_reg[cmd.comp]);
        mul_a = '0;
        mul_b = '0;
        if (cmd.op == CMD_PROD_SQ)
        begin
            mul_a = $signed({1'b0, mag_sel});
            mul_b = $signed({1'b0, mag_sel});
        end
        else
        begin
            // cross term pairs: x = y*oz - z*oy, y = z*ox - x*oz, z = x*oy - y*ox
            case ({cmd.comp, cmd.half})
                3'b000:
                begin
                    mul_a = (DATA_W+1)'(vec_reg[1]);
                    mul_b = (DATA_W+1)'(op_reg[2]);
                end
                3'b001:
                begin
                    mul_a = (DATA_W+1)'(vec_reg[2]);
                    mul_b = (DATA_W+1)'(op_reg[1]);
                end
                3'b010:
                begin
                    mul_a = (DATA_W+1)'(vec_reg[2]);
                    mul_b = (DATA_W+1)'(op_reg[0]);
                end
                3'b011:
                begin
                    mul_a = (DATA_W+1)'(vec_reg[0]);
                    mul_b = (DATA_W+1)'(op_reg[2]);
                end
                3'b100:
                begin
                    mul_a = (DATA_W+1)'(vec_reg[0]);
                    mul_b = (DATA_W+1)'(op_reg[1]);
                end
                3'b101:
                begin
                    mul_a = (DATA_W+1)'(vec_reg[1]);
                    mul_b = (DATA_W+1)'(op_reg[0]);
                end
                default:
                begin
                    mul_a = '0;
                    mul_b = '0;
                end
            endcase
        end
        mul_p = mul_a * mul_b;

        for (int i = 0; i < 3; i++)
            sum[i] = (DATA_W+1)'(vec_reg[i]) + (DATA_W+1)'(op_reg[i]);

        acc_sh = acc_reg >>> FRAC_BITS;
        cr_ovf = (acc_sh[ACC_W-1:DATA_W-1] != '0) && (acc_sh[ACC_W-1:DATA_W-1] != '1);
        cr_val = cr_ovf ? (acc_sh[ACC_W-1] ? S_MIN : S_MAX) : acc_sh[DATA_W-1:0];

        s_sh    = {srem_reg, rad_reg[PROD_W-1 -: 2]};
        s_trial = {2'b00, root_reg, 2'b01};

        divisor = (root_reg == '0) ? DATA_W'(1) : root_reg;
        d_sh    = {drem_reg, dvd_reg[DIV_W-1]};
        q_lo    = quo_reg[DATA_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg <= KIND_LOAD;
            for (int i = 0; i < 3; i++)
            begin
                op_reg[i]  <= '0;
                vec_reg[i] <= '0;
                res_reg[i] <= '0;
            end
            sat_reg  <= 1'b0;
            prod_reg <= '0;
            acc_reg  <= '0;
            rad_reg  <= '0;
            srem_reg <= '0;
            root_reg <= '0;
            dvd_reg  <= '0;
            drem_reg <= '0;
            quo_reg  <= '0;
            ox_reg   <= '0;
            oy_reg   <= '0;
            oz_reg   <= '0;
            osat_reg <= 1'b0;
        end
        else
        begin
            case (cmd.op)
                CMD_LATCH:
                begin
                    kind_reg  <= kind_t'(in_kind);
                    op_reg[0] <= in_x;
                    op_reg[1] <= in_y;
                    op_reg[2] <= in_z;
                    sat_reg   <= 1'b0;
                end
                CMD_LOAD:
                begin
                    for (int i = 0; i < 3; i++)
                        vec_reg[i] <= op_reg[i];
                end
                CMD_ADD:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        if (sum[i][DATA_W] != sum[i][DATA_W-1])
                        begin
                            vec_reg[i] <= sum[i][DATA_W] ? S_MIN : S_MAX;
                            sat_reg    <= 1'b1;
                        end
                        else
                            vec_reg[i] <= sum[i][DATA_W-1:0];
                    end
                end
                CMD_PROD_CR, CMD_PROD_SQ: prod_reg <= mul_p[PROD_W-1:0];
                CMD_ACC_SET: acc_reg <= ACC_W'(prod_reg);
                CMD_ACC_ADD: acc_reg <= acc_reg + ACC_W'(prod_reg);
                CMD_ACC_SUB: acc_reg <= acc_reg - ACC_W'(prod_reg);
                CMD_CR_WR:
                begin
                    res_reg[cmd.comp] <= cr_val;
                    if (cr_ovf)
                        sat_reg <= 1'b1;
                end
                CMD_SQRT_INIT:
                begin
                    rad_reg  <= acc_reg[PROD_W-1:0];
                    srem_reg <= '0;
                    root_reg <= '0;
                end
                CMD_SQRT_STEP:
                begin
                    rad_reg <= rad_reg << 2;
                    if (s_sh >= s_trial)
                    begin
                        srem_reg <= (DATA_W+2)'(s_sh - s_trial);
                        root_reg <= {root_reg[DATA_W-2:0], 1'b1};
                    end
                    else
                    begin
                        srem_reg <= (DATA_W+2)'(s_sh);
                        root_reg <= {root_reg[DATA_W-2:0], 1'b0};
                    end
                end
                CMD_DIV_INIT:
                begin
                    dvd_reg  <= {mag_sel, {FRAC_BITS{1'b0}}};
                    drem_reg <= '0;
                    quo_reg  <= '0;
                end
                CMD_DIV_STEP:
                begin
                    dvd_reg <= dvd_reg << 1;
                    if (d_sh >= {1'b0, divisor})
                    begin
                        drem_reg <= DATA_W'(d_sh - {1'b0, divisor});
                        quo_reg  <= {quo_reg[DIV_W-2:0], 1'b1};
                    end
                    else
                    begin
                        drem_reg <= d_sh[DATA_W-1:0];
                        quo_reg  <= {quo_reg[DIV_W-2:0], 1'b0};
                    end
                end
                CMD_DIV_WR:
                    res_reg[cmd.comp] <= vec_reg[cmd.comp][DATA_W-1] ? -q_lo : q_lo;
                CMD_COMMIT:
                begin
                    for (int i = 0; i < 3; i++)
                        vec_reg[i] <= res_reg[i];
                end
                CMD_OUT:
                begin
                    ox_reg   <= vec_reg[0];
                    oy_reg   <= vec_reg[1];
                    oz_reg   <= vec_reg[2];
                    osat_reg <= sat_reg;
                end
                default: ;
            endcase
        end
    end

    assign status.kind     = kind_reg;
    assign status.vec_zero = (vec_reg[0] == '0) && (vec_reg[1] == '0) && (vec_reg[2] == '0);
    assign out_x   = ox_reg;
    assign out_y   = oy_reg;
    assign out_z   = oz_reg;
    assign out_sat = osat_reg;

endmodule
`default_nettype wire

### rtl/v3acc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module v3acc_ctrl
    import v3acc_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  wire logic    out_ready,
    input  wire status_t status,
    output cmd_t         cmd
);

    state_t           state_reg, state_next;
    logic [1:0]       comp_reg, comp_next;
    logic             half_reg, half_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             ovalid_reg, ovalid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            comp_reg   <= '0;
            half_reg   <= 1'b0;
            cnt_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            comp_reg   <= comp_next;
            half_reg   <= half_next;
            cnt_reg    <= cnt_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        comp_next   = comp_reg;
        half_next   = half_reg;
        cnt_next    = cnt_reg;
        ovalid_next = ovalid_reg && !out_ready;
        in_ready    = 1'b0;
        cmd.op      = CMD_NOP;
        cmd.comp    = comp_reg;
        cmd.half    = half_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = CMD_LATCH;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                comp_next = '0;
                half_next = 1'b0;
                case (status.kind)
                    KIND_LOAD:
                    begin
                        cmd.op     = CMD_LOAD;
                        state_next = ST_DONE;
                    end
                    KIND_ADD:
                    begin
                        cmd.op     = CMD_ADD;
                        state_next = ST_DONE;
                    end
                    KIND_CROSS: state_next = ST_CR_PROD;
                    default:    state_next = status.vec_zero ? ST_DONE : ST_SQ_PROD;
                endcase
            end
            ST_CR_PROD:
            begin
                cmd.op     = CMD_PROD_CR;
                state_next = ST_CR_ACC;
            end
            ST_CR_ACC:
            begin
                cmd.op = half_reg ? CMD_ACC_SUB : CMD_ACC_SET;
                if (!half_reg)
                begin
                    half_next  = 1'b1;
                    state_next = ST_CR_PROD;
                end
                else
                    state_next = ST_CR_WR;
            end
            ST_CR_WR:
            begin
                cmd.op    = CMD_CR_WR;
                half_next = 1'b0;
                if (comp_reg == 2'd2)
                    state_next = ST_COMMIT;
                else
                begin
                    comp_next  = comp_reg + 2'd1;
                    state_next = ST_CR_PROD;
                end
            end
            ST_SQ_PROD:
            begin
                cmd.op     = CMD_PROD_SQ;
                state_next = ST_SQ_ACC;
            end
            ST_SQ_ACC:
            begin
                cmd.op = (comp_reg == 2'd0) ? CMD_ACC_SET : CMD_ACC_ADD;
                if (comp_reg == 2'd2)
                    state_next = ST_SQRT_INIT;
                else
                begin
                    comp_next  = comp_reg + 2'd1;
                    state_next = ST_SQ_PROD;
                end
            end
            ST_SQRT_INIT:
            begin
                cmd.op     = CMD_SQRT_INIT;
                cnt_next   = CNT_W'(SQRT_STEPS - 1);
                state_next = ST_SQRT_STEP;
            end
            ST_SQRT_STEP:
            begin
                cmd.op = CMD_SQRT_STEP;
                if (cnt_reg == '0)
                begin
                    comp_next  = '0;
                    state_next = ST_DIV_INIT;
                end
                else
                    cnt_next = cnt_reg - 1'b1;
            end
            ST_DIV_INIT:
            begin
                cmd.op     = CMD_DIV_INIT;
                cnt_next   = CNT_W'(DIV_W - 1);
                state_next = ST_DIV_STEP;
            end
            ST_DIV_STEP:
            begin
                cmd.op = CMD_DIV_STEP;
                if (cnt_reg == '0)
                    state_next = ST_DIV_WR;
                else
                    cnt_next = cnt_reg - 1'b1;
            end
            ST_DIV_WR:
            begin
                cmd.op = CMD_DIV_WR;
                if (comp_reg == 2'd2)
                    state_next = ST_COMMIT;
                else
                begin
                    comp_next  = comp_reg + 2'd1;
                    state_next = ST_DIV_INIT;
                end
            end
            ST_COMMIT:
            begin
                cmd.op     = CMD_COMMIT;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // wait for the output register to drain
                if (!ovalid_reg || out_ready)
                begin
                    cmd.op      = CMD_OUT;
                    ovalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign out_valid = ovalid_reg;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_EXEC))
        else $error("accepted word did not start execution");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside done state");

    a_comp_range: assert property (@(posedge clk) disable iff (!rst_n)
        comp_reg != 2'd3)
        else $error("component index out of range");

    a_div_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV_STEP) |-> (cnt_reg < CNT_W'(DIV_W)))
        else $error("division step count out of range");

endmodule
`default_nettype wire

### rtl/vector3_accumulator_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// 3D vector accumulator. Holds one vector in three signed Q16.16 registers
// (zero after reset) and applies one operation per input word, selected by
// s_tuser: load, saturating add, cross product (held x operand, products
// floored to Q16.16 and clamped) and normalize (vector / floor(sqrt(sum of
// squares)), truncated toward zero; a zero vector stays unchanged). Every
// input word yields exactly one output word with the new vector and a flag
// that is set if any component was clamped. One word is worked on at a
// time; a finished result waits in an output register, so the next word may
// be accepted while it is pending. The cross product runs six products on
// one shared 33x33 multiplier; normalize uses a 32-step bit-serial square
// root and three 48-step restoring divisions on a single divider.
module vector3_accumulator_alu
    import v3acc_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [95:0]   s_tdata,   // in_x[31:0], in_y[63:32], in_z[95:64]
    input  wire logic [1:0]    s_tuser,   // kind[1:0]
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [95:0]        m_tdata,   // out_x[31:0], out_y[63:32], out_z[95:64]
    output logic               m_tuser    // saturated
);

    cmd_t    cmd;
    status_t status;
    logic signed [DATA_W-1:0] ox, oy, oz;

    v3acc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .status    (status),
        .cmd       (cmd)
    );

    v3acc_dpath u_dpath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .status  (status),
        .in_kind (s_tuser),
        .in_x    (s_tdata[31:0]),
        .in_y    (s_tdata[63:32]),
        .in_z    (s_tdata[95:64]),
        .out_x   (ox),
        .out_y   (oy),
        .out_z   (oz),
        .out_sat (m_tuser)
    );

    assign m_tdata = {oz, oy, ox};

endmodule
`default_nettype wire
